@@ rtl/lpd_pkg.sv @@
`timescale 1ns / 1ps

package lpd_pkg;

  // Header field sizes in bytes
  localparam int unsigned LEN_BYTES  = 4;
  localparam int unsigned TYPE_BYTES = 2;
  localparam int unsigned JSZ_BYTES  = 4;
  localparam int unsigned MIN_LENGTH = TYPE_BYTES + JSZ_BYTES;

  localparam logic [31:0] MIN_LENGTH_W = 32'(MIN_LENGTH);

  // Byte counter within a header field
  typedef logic [1:0] hdr_cnt_t;

  localparam hdr_cnt_t LEN_LAST  = hdr_cnt_t'(LEN_BYTES - 1);
  localparam hdr_cnt_t TYPE_LAST = hdr_cnt_t'(TYPE_BYTES - 1);
  localparam hdr_cnt_t JSZ_LAST  = hdr_cnt_t'(JSZ_BYTES - 1);

  localparam logic SEC_JSON   = 1'b0;
  localparam logic SEC_BINARY = 1'b1;

  typedef struct packed {
    logic [15:0] msg_type;
    logic        section;
    logic [7:0]  payload_byte;
    logic        has_data;
    logic        end_of_packet;
  } result_t;

endpackage

@@ rtl/lpd_if.sv @@
`timescale 1ns / 1ps

interface lpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       chunk_end;

  modport source (output valid, output rx_byte, output chunk_end, input ready);
  modport sink (input valid, input rx_byte, input chunk_end, output ready);
endinterface

interface lpd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] msg_type;
  logic        section;
  logic [7:0]  payload_byte;
  logic        has_data;
  logic        end_of_packet;

  modport source (
    output valid, output msg_type, output section, output payload_byte,
    output has_data, output end_of_packet, input ready
  );
  modport sink (
    input valid, input msg_type, input section, input payload_byte,
    input has_data, input end_of_packet, output ready
  );
endinterface

@@ rtl/length_prefixed_deframer_top.sv @@
`timescale 1ns / 1ps

// Length-prefixed message deframer.
// Input channel in_i carries one stream byte per transfer, rx_byte with
// chunk_end marking the last byte of a received chunk. Packets are a
// 4-byte big-endian length (counted from the type field), a 2-byte type,
// a 4-byte JSON size, the JSON bytes, then the binary bytes.
// Output channel out_o carries at most one result per input transfer: a
// payload byte tagged with msg_type and section, or a data-less marker for
// an empty packet; end_of_packet flags the last result of a packet.
// Throughput: one byte per cycle, sustained while out_o.ready stays high;
// each byte only updates the parser registers and counters, and the next
// byte is taken in the same cycle as a waiting result transfers.
// A result appears on out_o in the cycle after the byte transfer that
// causes it.
// Reset: the parser returns to the length field and the output register
// empties.
// Stall: while a result is held and out_o.ready is low, in_i.ready drops;
// the held result stays stable until its transfer.
module length_prefixed_deframer_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  lpd_in_if.sink    in_i,
  lpd_out_if.source out_o
);

  logic             step;
  logic             res_valid;
  lpd_pkg::result_t res;

  logic             out_valid_q, out_valid_d;
  lpd_pkg::result_t out_q;

  // Take a byte whenever the result slot is free or being drained now
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign step       = in_i.valid && in_i.ready;

  lpd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .rx_byte_i   (in_i.rx_byte),
    .chunk_end_i (in_i.chunk_end),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      // load the new result, or empty the slot if the byte gives none
      out_valid_d = res_valid;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Payload holds unless a new result is loaded
  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.msg_type      = out_q.msg_type;
  assign out_o.section       = out_q.section;
  assign out_o.payload_byte  = out_q.payload_byte;
  assign out_o.has_data      = out_q.has_data;
  assign out_o.end_of_packet = out_q.end_of_packet;

endmodule

@@ rtl/lpd_parser.sv @@
`timescale 1ns / 1ps

module lpd_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       rx_byte_i,
  input  logic             chunk_end_i,
  output logic             res_valid_o,
  output lpd_pkg::result_t res_o
);

  typedef enum logic [2:0] {
    PH_LEN,
    PH_TYPE,
    PH_JSZ,
    PH_PAYLOAD,
    PH_SKIP,
    PH_DISCARD
  } phase_e;

  phase_e            phase_q, phase_d;
  lpd_pkg::hdr_cnt_t cnt_q, cnt_d;
  logic [31:0]       frame_len_q, frame_len_d;
  logic [15:0]       type_q, type_d;
  logic [31:0]       json_len_q, json_len_d;
  logic [31:0]       pay_left_q, pay_left_d;
  logic [31:0]       json_left_q, json_left_d;

  logic [31:0] jsz_full;
  logic [31:0] pay_size;
  logic [31:0] pay_dec;

  assign jsz_full = {json_len_q[23:0], rx_byte_i};
  assign pay_size = frame_len_q - lpd_pkg::MIN_LENGTH_W;
  assign pay_dec  = (pay_left_q != 32'd0) ? pay_left_q - 32'd1 : pay_left_q;

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    frame_len_d = frame_len_q;
    type_d      = type_q;
    json_len_d  = json_len_q;
    pay_left_d  = pay_left_q;
    json_left_d = json_left_q;
    res_valid_o = 1'b0;
    res_o       = '{msg_type: type_q, section: lpd_pkg::SEC_JSON, payload_byte: 8'd0,
                    has_data: 1'b0, end_of_packet: 1'b1};
    case (phase_q)
      PH_LEN: begin
        frame_len_d = {frame_len_q[23:0], rx_byte_i};
        cnt_d       = cnt_q + 2'd1;
        if (cnt_q == lpd_pkg::LEN_LAST) begin
          cnt_d = '0;
          if (frame_len_d < lpd_pkg::MIN_LENGTH_W) begin
            phase_d = chunk_end_i ? PH_LEN : PH_DISCARD;
          end else begin
            phase_d = PH_TYPE;
          end
        end
      end
      PH_DISCARD: begin
        if (chunk_end_i) begin
          phase_d = PH_LEN;
          cnt_d   = '0;
        end
      end
      PH_TYPE: begin
        type_d = {type_q[7:0], rx_byte_i};
        cnt_d  = cnt_q + 2'd1;
        if (cnt_q == lpd_pkg::TYPE_LAST) begin
          cnt_d   = '0;
          phase_d = PH_JSZ;
        end
      end
      PH_JSZ: begin
        json_len_d = jsz_full;
        cnt_d      = cnt_q + 2'd1;
        if (cnt_q == lpd_pkg::JSZ_LAST) begin
          cnt_d      = '0;
          pay_left_d = pay_size;
          if (jsz_full > pay_size) begin
            phase_d = (pay_size == 32'd0) ? PH_LEN : PH_SKIP;
          end else begin
            json_left_d = jsz_full;
            if (pay_size == 32'd0) begin
              // empty packet: one marker without data
              phase_d     = PH_LEN;
              res_valid_o = 1'b1;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        res_valid_o        = 1'b1;
        res_o.has_data     = 1'b1;
        res_o.payload_byte = rx_byte_i;
        if (json_left_q != 32'd0) begin
          res_o.section = lpd_pkg::SEC_JSON;
          json_left_d   = json_left_q - 32'd1;
        end else begin
          res_o.section = lpd_pkg::SEC_BINARY;
        end
        pay_left_d          = pay_dec;
        res_o.end_of_packet = (pay_dec == 32'd0);
        if (pay_dec == 32'd0) begin
          phase_d = PH_LEN;
          cnt_d   = '0;
        end
      end
      PH_SKIP: begin
        pay_left_d = pay_dec;
        if (pay_dec == 32'd0) begin
          phase_d = PH_LEN;
          cnt_d   = '0;
        end
      end
      default: begin
        phase_d = PH_LEN;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEN;
      cnt_q       <= '0;
      frame_len_q <= '0;
      type_q      <= '0;
      json_len_q  <= '0;
      pay_left_q  <= '0;
      json_left_q <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      frame_len_q <= frame_len_d;
      type_q      <= type_d;
      json_len_q  <= json_len_d;
      pay_left_q  <= pay_left_d;
      json_left_q <= json_left_d;
    end
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  // Parser phases of the deframer as the bench tracks them
  typedef enum logic [2:0] {
    PH_LENGTH,
    PH_TYPE,
    PH_JSON_SIZE,
    PH_PAYLOAD,
    PH_SKIP,
    PH_DROP
  } phase_e;

  // Full parser state; one copy feeds the checker, one steers the generator
  typedef struct packed {
    phase_e      phase;
    logic [3:0]  cnt;
    logic [31:0] frame_len;
    logic [15:0] pkt_type;
    logic [31:0] json_size;
    logic [31:0] payload_left;
    logic [31:0] json_left;
  } deframer_t;

  typedef struct packed {
    deframer_t        st;
    logic             emits;
    lpd_pkg::result_t res;
  } step_t;

  typedef struct packed {
    logic [7:0] data;
    logic       chunk_end;
  } stream_byte_t;

  localparam int unsigned HOLD_CYCLES   = 80;    // long receiver hold-off
  localparam int unsigned STALL_LIMIT   = 2000;  // cycles without any transfer
  localparam int unsigned DRAIN_CYCLES  = 8;     // settle time after the last result
  localparam int unsigned RANDOM_TARGET = 880;   // stream bytes before the final packet

  logic clk = 1'b0;
  logic rst_n;

  lpd_in_if  in_if ();
  lpd_out_if out_if ();

  length_prefixed_deframer_top i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  stream_byte_t     pending_bytes[$];
  lpd_pkg::result_t expected_results[$];

  deframer_t    gen_st;        // generator view of the parser, used to resync
  deframer_t    chk_st;        // checker view of the parser
  step_t        mon_step;
  step_t        gen_step;
  stream_byte_t drv_item;

  int unsigned  bytes_sent;    // input transfers so far
  int unsigned  total_bytes;
  int unsigned  hold_at;
  int unsigned  hold_left;
  logic         hold_done;
  int unsigned  send_idle_pct = 20;
  int unsigned  recv_idle_pct = 49;
  int unsigned  quiet_cycles;
  int unsigned  fail_cnt = 0;

  // Advance the parser by one stream byte and report the result it yields.
  // Lengths and sizes are unsigned 32-bit, so the payload size never wraps
  // negative the way a signed count would.
  function automatic step_t deframe_byte(deframer_t s, logic [7:0] b, logic ce);
    step_t r;
    r.emits = 1'b0;
    r.res   = '0;
    case (s.phase)
      PH_LENGTH: begin
        s.frame_len = {s.frame_len[23:0], b};
        s.cnt = s.cnt + 4'd1;
        if (s.cnt == 4'(lpd_pkg::LEN_BYTES)) begin
          s.cnt = '0;
          // A short length drops bytes through the next chunk end; the byte
          // completing the length counts, so a chunk end on it drops nothing
          if (s.frame_len < lpd_pkg::MIN_LENGTH_W) begin
            s.phase = ce ? PH_LENGTH : PH_DROP;
          end else begin
            s.phase = PH_TYPE;
          end
        end
      end
      PH_DROP: begin
        if (ce) begin
          s.phase = PH_LENGTH;
          s.cnt   = '0;
        end
      end
      PH_TYPE: begin
        s.pkt_type = {s.pkt_type[7:0], b};
        s.cnt = s.cnt + 4'd1;
        if (s.cnt == 4'(lpd_pkg::TYPE_BYTES)) begin
          s.cnt   = '0;
          s.phase = PH_JSON_SIZE;
        end
      end
      PH_JSON_SIZE: begin
        s.json_size = {s.json_size[23:0], b};
        s.cnt = s.cnt + 4'd1;
        if (s.cnt == 4'(lpd_pkg::JSZ_BYTES)) begin
          s.cnt          = '0;
          s.payload_left = s.frame_len - lpd_pkg::MIN_LENGTH_W;
          if (s.json_size > s.payload_left) begin
            // Oversized JSON size: swallow the payload silently
            s.phase = (s.payload_left == '0) ? PH_LENGTH : PH_SKIP;
          end else begin
            s.json_left = s.json_size;
            if (s.payload_left == '0) begin
              // Empty packet: a single data-less marker
              s.phase                 = PH_LENGTH;
              r.emits                 = 1'b1;
              r.res.msg_type          = s.pkt_type;
              r.res.section           = lpd_pkg::SEC_JSON;
              r.res.end_of_packet     = 1'b1;
            end else begin
              s.phase = PH_PAYLOAD;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        r.emits            = 1'b1;
        r.res.msg_type     = s.pkt_type;
        r.res.payload_byte = b;
        r.res.has_data     = 1'b1;
        if (s.json_left != '0) begin
          r.res.section = lpd_pkg::SEC_JSON;
          s.json_left   = s.json_left - 32'd1;
        end else begin
          r.res.section = lpd_pkg::SEC_BINARY;
        end
        if (s.payload_left != '0) s.payload_left = s.payload_left - 32'd1;
        if (s.payload_left == '0) begin
          s.phase             = PH_LENGTH;
          s.cnt               = '0;
          r.res.end_of_packet = 1'b1;
        end
      end
      default: begin
        if (s.payload_left != '0) s.payload_left = s.payload_left - 32'd1;
        if (s.payload_left == '0) begin
          s.phase = PH_LENGTH;
          s.cnt   = '0;
        end
      end
    endcase
    r.st = s;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stream generation: queue a byte and track where the parser will be
  // ---------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b, logic ce);
    stream_byte_t item;
    gen_step       = deframe_byte(gen_st, b, ce);
    gen_st         = gen_step.st;
    item.data      = b;
    item.chunk_end = ce;
    pending_bytes.insert(pending_bytes.size(), item);
  endtask

  // Queue a packet header plus payload; stop after cut bytes (cut < 0: whole
  // packet). With alt set the payload alternates 0xFF and 0x00.
  task automatic send_packet(logic [31:0] len, logic [15:0] typ, logic [31:0] jsz,
                             int cut, int unsigned ce_pct, logic alt);
    logic [79:0] hdr;
    int          n;
    logic [7:0]  b;
    hdr = {len, typ, jsz};
    n   = (cut < 0) ? 10 + int'(len) - int'(lpd_pkg::MIN_LENGTH) : cut;
    for (int i = 0; i < n; i++) begin
      if (i < 10)   b = hdr[79 - 8*i -: 8];
      else if (alt) b = (i % 2 == 0) ? 8'hFF : 8'h00;
      else          b = 8'($urandom);
      send_byte(b, $urandom_range(0, 99) < ce_pct);
    end
  endtask

  // Queue a too-short length; when the completing byte carries no chunk end,
  // follow it with ndrop dropped bytes and a closing chunk end
  task automatic send_short(logic [7:0] len, logic ce_last, int unsigned ndrop);
    for (int i = 0; i < 3; i++) send_byte(8'h00, $urandom_range(0, 9) == 0);
    send_byte(len, ce_last);
    if (!ce_last) begin
      for (int i = 0; i < ndrop; i++) send_byte(8'($urandom), 1'b0);
      send_byte(8'($urandom), 1'b1);
    end
  endtask

  // Feed filler until the parser waits for a fresh length field again
  task automatic resync();
    while (!(gen_st.phase == PH_LENGTH && gen_st.cnt == '0)) begin
      if (gen_st.phase == PH_LENGTH)    send_byte(8'h00, 1'b1);
      else if (gen_st.phase == PH_DROP) send_byte(8'($urandom), 1'b1);
      else                              send_byte(8'($urandom), $urandom_range(0, 9) == 0);
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver: offer the next queued byte, hold it until its transfer
  // ---------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_if.valid     <= 1'b0;
      in_if.rx_byte   <= '0;
      in_if.chunk_end <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      // Keep offering during the long hold-off so the block backs up
      if (pending_bytes.size() != 0 &&
          (hold_left != 0 || $urandom_range(0, 99) >= send_idle_pct)) begin
        drv_item         = pending_bytes.pop_front();
        in_if.valid     <= 1'b1;
        in_if.rx_byte   <= drv_item.data;
        in_if.chunk_end <= drv_item.chunk_end;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: random back-pressure plus one long hold-off
  // ---------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (!hold_done && bytes_sent >= hold_at) begin
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= $urandom_range(0, 99) >= recv_idle_pct;
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_cnt++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Monitor: predict on every byte transfer first, then check the result
  // transfer of the same edge against the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      chk_st     = '0;
      bytes_sent <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        mon_step = deframe_byte(chk_st, in_if.rx_byte, in_if.chunk_end);
        chk_st   = mon_step.st;
        if (mon_step.emits) expected_results.insert(expected_results.size(), mon_step.res);
        bytes_sent <= bytes_sent + 1;
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: msg_type 0x%0h byte 0x%0h",
                 out_if.msg_type, out_if.payload_byte);
          fail_cnt++;
        end else begin
          mon_step.res = expected_results.pop_front();
          check_field("msg_type", 32'(mon_step.res.msg_type), 32'(out_if.msg_type));
          check_field("section", 32'(mon_step.res.section), 32'(out_if.section));
          check_field("payload_byte", 32'(mon_step.res.payload_byte),
                      32'(out_if.payload_byte));
          check_field("has_data", 32'(mon_step.res.has_data), 32'(out_if.has_data));
          check_field("end_of_packet", 32'(mon_step.res.end_of_packet),
                      32'(out_if.end_of_packet));
        end
      end
    end
  end

  // Watchdog: end the run when neither channel moves for too long
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [31:0] len;
    logic [31:0] jsz;
    int unsigned kind;

    // Hold reset; the driver and receiver drive known values meanwhile
    rst_n  = 1'b0;
    gen_st = '0;

    // Directed: empty packet with the all-ones type
    send_packet(32'd6, 16'hFFFF, 32'd0, -1, 0, 1'b0);
    // Short lengths: chunk end on the completing byte, then one that drops
    send_short(8'd0, 1'b1, 0);
    send_short(8'd5, 1'b0, 2);
    // Oversized JSON size with no payload, then the largest size
    send_packet(32'd6, 16'h1234, 32'd1, -1, 0, 1'b0);
    send_packet(32'd9, 16'h8001, 32'hFFFF_FFFF, -1, 0, 1'b0);
    // JSON only with extreme bytes, type zero
    send_packet(32'd8, 16'h0000, 32'd2, -1, 0, 1'b1);
    // Binary only, chunk end on every byte (no effect outside dropping)
    send_packet(32'd8, 16'h7FFE, 32'd0, -1, 100, 1'b1);
    // Mixed sections
    send_packet(32'd9, 16'h5AA5, 32'd1, -1, 0, 1'b0);

    // Random: mostly well-formed packets, some short lengths and cut packets
    while (pending_bytes.size() < RANDOM_TARGET) begin
      kind = $urandom_range(0, 99);
      len  = ($urandom_range(0, 19) == 0) ? 6 + $urandom_range(0, 250)
                                          : 6 + $urandom_range(0, 16);
      if ($urandom_range(0, 4) != 0)      jsz = $urandom_range(0, len - 6);
      else if ($urandom_range(0, 3) == 0) jsz = $urandom;
      else                                jsz = len - 6 + 1 + $urandom_range(0, 3);
      if (kind < 75) begin
        send_packet(len, 16'($urandom), jsz, -1, 10, 1'b0);
      end else if (kind < 87) begin
        send_short(8'($urandom_range(0, 5)), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 6));
      end else begin
        send_packet(len, 16'($urandom), jsz, $urandom_range(1, len + 3), 10, 1'b0);
        resync();
      end
    end

    // Last: the largest length, far beyond what the run sends; the parser
    // stays in the payload, so nothing may follow it
    send_packet(32'hFFFF_FFFF, 16'hA5C3, 32'd3, 18, 10, 1'b0);

    total_bytes = pending_bytes.size();
    hold_at     = total_bytes / 2;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Swap the idle rates after a third, drop idling after two thirds
    wait (bytes_sent >= total_bytes / 3);
    send_idle_pct = 49;
    recv_idle_pct = 20;
    wait (bytes_sent >= 2 * total_bytes / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;

    wait (bytes_sent == total_bytes);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
